// ===== design/assert_macros.svh =====
// Concurrent assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg)

`define ASSERT_CLK(lbl, clk, prop, msg)

`endif

`endif

// ===== design/bmpp_pkg.sv =====
package bmpp_pkg;

  localparam logic [7:0] SYSEX_LIMIT_RESET = 8'd192;

  localparam logic [7:0] ST_SYSEX_START = 8'hF0;
  localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
  localparam logic [7:0] ST_REALTIME    = 8'hF8;
  localparam logic [7:0] ST_MTC_QUARTER = 8'hF1;
  localparam logic [7:0] ST_SONG_POS    = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL    = 8'hF3;

  localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
  localparam logic [3:0] HI_NOTE_ON   = 4'h9;
  localparam logic [3:0] HI_CTRL      = 4'hB;
  localparam logic [3:0] HI_PROGRAM   = 4'hC;
  localparam logic [3:0] HI_PRESSURE  = 4'hD;

  typedef enum logic [2:0] {
    EV_NOTE_OFF    = 3'd0,
    EV_NOTE_ON     = 3'd1,
    EV_CTRL_CHANGE = 3'd2,
    EV_PROG_CHANGE = 3'd3,
    EV_SYSEX_BYTE  = 3'd4,
    EV_SYSEX_OK    = 3'd5,
    EV_SYSEX_ABORT = 3'd6
  } event_kind_t;

  typedef struct packed {
    event_kind_t kind;
    logic [3:0]  channel;
    logic [6:0]  data_one;
    logic [6:0]  data_two;
    logic [7:0]  sysex_length;
  } event_t;

endpackage

// ===== design/ble_midi_packet_parser_unit.sv =====
// An accepted word is held in the input register, and its event is then registered in the output register.
// Throughput: one packet byte per cycle while out_stall does not hold the output; every byte is parsed in a single pass
// between the input register and the output register, with at most one event.
// Reset (rst, synchronous, active high) empties both registers, clears the parser
// state and running status, and sets sysex_limit to 192.
`include "assert_macros.svh"

module ble_midi_packet_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  packet_byte,
  input  logic        first_in_packet,
  input  logic        last_in_packet,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_kind,
  output logic [3:0]  channel,
  output logic [6:0]  data_one,
  output logic [6:0]  data_two,
  output logic [7:0]  sysex_length,
  output logic        last_of_run
);
  import bmpp_pkg::*;

  typedef enum logic [2:0] {
    PH_TOP      = 3'd0,
    PH_AFTER_TS = 3'd1,
    PH_DATA1    = 3'd2,
    PH_DATA2    = 3'd3,
    PH_SKIP     = 3'd4,
    PH_SX_TS    = 3'd5
  } phase_t;

  logic [7:0] sysex_limit;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_first;
  logic       s1_last;

  phase_t     parse_phase, parse_phase_next;
  logic       inside_sysex, inside_sysex_next;
  logic [7:0] sysex_count, sysex_count_next;
  logic [7:0] running_status, running_status_next;
  logic [6:0] held_data_byte, held_data_byte_next;
  logic [1:0] skip_remaining, skip_remaining_next;

  event_t     result;
  event_t     res_next;
  logic       emit;

  logic       hold;
  logic       advance;
  logic       sx_now;
  logic [3:0] rs_hi;
  logic       sd_single;
  logic [1:0] skip_dec;

  assign hold     = out_valid && out_stall;
  assign advance  = s1_valid && !hold;
  assign in_stall = s1_valid && hold;

  assign rs_hi     = running_status[7:4];
  assign sd_single = (rs_hi == HI_PROGRAM) || (rs_hi == HI_PRESSURE);
  assign skip_dec  = (skip_remaining != 2'd0) ? skip_remaining - 2'd1 : 2'd0;

  always_comb begin
    parse_phase_next    = parse_phase;
    inside_sysex_next   = inside_sysex;
    sysex_count_next    = sysex_count;
    running_status_next = running_status;
    held_data_byte_next = held_data_byte;
    skip_remaining_next = skip_remaining;
    emit                = 1'b0;
    res_next            = '{kind: EV_NOTE_OFF, channel: 4'd0, data_one: 7'd0,
                            data_two: 7'd0, sysex_length: 8'd0};
    sx_now              = inside_sysex;

    if (s1_first) begin
      if (parse_phase == PH_SX_TS && inside_sysex) begin
        emit                  = 1'b1;
        res_next.kind         = EV_SYSEX_ABORT;
        res_next.sysex_length = sysex_count;
        inside_sysex_next     = 1'b0;
        sysex_count_next      = 8'd0;
      end
      parse_phase_next    = PH_TOP;
      skip_remaining_next = 2'd0;
    end else begin
      case (parse_phase)
        PH_AFTER_TS: begin
          parse_phase_next = PH_TOP;
          if (!s1_byte[7]) begin
            if (running_status != 8'd0) begin
              if (sd_single) begin
                emit             = (rs_hi == HI_PROGRAM);
                res_next.kind    = EV_PROG_CHANGE;
                res_next.channel = running_status[3:0];
                res_next.data_one = s1_byte[6:0];
              end else begin
                held_data_byte_next = s1_byte[6:0];
                parse_phase_next    = PH_DATA2;
              end
            end
          end else if (s1_byte == ST_SYSEX_START) begin
            inside_sysex_next   = 1'b1;
            sysex_count_next    = 8'd0;
            running_status_next = 8'd0;
          end else if (s1_byte >= ST_REALTIME || s1_byte == ST_SYSEX_END) begin
            parse_phase_next = PH_TOP;
          end else if (s1_byte >= ST_MTC_QUARTER) begin
            running_status_next = 8'd0;
            if (s1_byte == ST_SONG_POS) begin
              skip_remaining_next = 2'd2;
              parse_phase_next    = PH_SKIP;
            end else if (s1_byte inside {ST_MTC_QUARTER, ST_SONG_SEL}) begin
              skip_remaining_next = 2'd1;
              parse_phase_next    = PH_SKIP;
            end else begin
              skip_remaining_next = 2'd0;
            end
          end else begin
            running_status_next = s1_byte;
            parse_phase_next    = PH_DATA1;
          end
        end
        PH_DATA1: begin
          if (sd_single) begin
            emit              = (rs_hi == HI_PROGRAM);
            res_next.kind     = EV_PROG_CHANGE;
            res_next.channel  = running_status[3:0];
            res_next.data_one = s1_byte[6:0];
            parse_phase_next  = PH_TOP;
          end else begin
            held_data_byte_next = s1_byte[6:0];
            parse_phase_next    = PH_DATA2;
          end
        end
        PH_DATA2: begin
          parse_phase_next  = PH_TOP;
          res_next.channel  = running_status[3:0];
          res_next.data_one = held_data_byte;
          res_next.data_two = s1_byte[6:0];
          case (rs_hi)
            HI_NOTE_OFF: begin
              emit          = 1'b1;
              res_next.kind = EV_NOTE_OFF;
            end
            HI_NOTE_ON: begin
              emit          = 1'b1;
              res_next.kind = EV_NOTE_ON;
            end
            HI_CTRL: begin
              emit          = 1'b1;
              res_next.kind = EV_CTRL_CHANGE;
            end
            HI_PROGRAM: begin
              emit              = 1'b1;
              res_next.kind     = EV_PROG_CHANGE;
              res_next.data_two = 7'd0;
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
        PH_SKIP: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == 2'd0) begin
            parse_phase_next = PH_TOP;
          end
        end
        default: begin
          // Top position; a SysEx timestamp first resolves its terminator.
          parse_phase_next = PH_TOP;
          if (parse_phase == PH_SX_TS && inside_sysex) begin
            emit                  = 1'b1;
            res_next.sysex_length = sysex_count;
            inside_sysex_next     = 1'b0;
            sysex_count_next      = 8'd0;
            sx_now                = 1'b0;
            res_next.kind         = (s1_byte == ST_SYSEX_END) ? EV_SYSEX_OK : EV_SYSEX_ABORT;
          end
          if (!(parse_phase == PH_SX_TS && inside_sysex && s1_byte == ST_SYSEX_END)) begin
            if (sx_now) begin
              if (s1_byte[7]) begin
                if (s1_last) begin
                  emit                  = 1'b1;
                  res_next.kind         = EV_SYSEX_ABORT;
                  res_next.sysex_length = sysex_count;
                  inside_sysex_next     = 1'b0;
                  sysex_count_next      = 8'd0;
                end else begin
                  parse_phase_next = PH_SX_TS;
                end
              end else if (sysex_count < sysex_limit) begin
                emit              = 1'b1;
                res_next.kind     = EV_SYSEX_BYTE;
                res_next.data_one = s1_byte[6:0];
                sysex_count_next  = sysex_count + 8'd1;
              end else begin
                emit                  = 1'b1;
                res_next.kind         = EV_SYSEX_ABORT;
                res_next.sysex_length = sysex_count;
                inside_sysex_next     = 1'b0;
                sysex_count_next      = 8'd0;
              end
            end else if (s1_byte[7]) begin
              parse_phase_next = PH_AFTER_TS;
            end else if (running_status != 8'd0) begin
              if (sd_single) begin
                emit              = (rs_hi == HI_PROGRAM);
                res_next.kind     = EV_PROG_CHANGE;
                res_next.channel  = running_status[3:0];
                res_next.data_one = s1_byte[6:0];
              end else begin
                held_data_byte_next = s1_byte[6:0];
                parse_phase_next    = PH_DATA2;
              end
            end
          end
        end
      endcase
    end

    if (s1_last) begin
      parse_phase_next    = PH_TOP;
      skip_remaining_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sysex_limit    <= SYSEX_LIMIT_RESET;
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      parse_phase    <= PH_TOP;
      inside_sysex   <= 1'b0;
      sysex_count    <= 8'd0;
      running_status <= 8'd0;
      held_data_byte <= 7'd0;
      skip_remaining <= 2'd0;
    end else begin
      if (cfg_we) begin
        sysex_limit <= cfg_data;
      end
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (!hold) begin
        out_valid <= advance && emit;
      end
      if (advance) begin
        parse_phase    <= parse_phase_next;
        inside_sysex   <= inside_sysex_next;
        sysex_count    <= sysex_count_next;
        running_status <= running_status_next;
        held_data_byte <= held_data_byte_next;
        skip_remaining <= skip_remaining_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte  <= packet_byte;
      s1_first <= first_in_packet;
      s1_last  <= last_in_packet;
    end
    if (advance && emit) begin
      result <= res_next;
    end
  end

  assign event_kind   = result.kind;
  assign channel      = result.channel;
  assign data_one     = result.data_one;
  assign data_two     = result.data_two;
  assign sysex_length = result.sysex_length;
  assign last_of_run  = 1'b1;

  `ASSERT_CLK_RST(a_sysex_no_running, clk, rst, inside_sysex |-> running_status == 8'd0, "running status set inside SysEx")
  `ASSERT_CLK_RST(a_sx_ts_in_sysex, clk, rst, parse_phase == PH_SX_TS |-> inside_sysex, "SysEx timestamp phase outside SysEx")
  `ASSERT_CLK_RST(a_stall_needs_out, clk, rst, in_stall |-> out_valid && s1_valid, "input stalled with free output")
  `ASSERT_CLK(a_reset_empties, clk, rst |=> !out_valid && !s1_valid, "registers not emptied by reset")

endmodule

// ===== tb/sv/tb_ble_midi_packet_parser_unit.sv =====
module tb_ble_midi_packet_parser_unit;
  import bmpp_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 90;
  localparam int SETTLE_CYCLES = 10;

  typedef struct packed {
    event_t ev;
    logic   last;
  } event_word_t;

  typedef enum logic [2:0] {
    PARSE_GROUP,
    PARSE_AFTER_STAMP,
    PARSE_FIRST_DATA,
    PARSE_SECOND_DATA,
    PARSE_SKIP,
    PARSE_SYSEX_STAMP
  } parse_state_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_style_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] packet_byte = 8'd0;
  logic       first_in_packet = 1'b0;
  logic       last_in_packet = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] event_kind;
  logic [3:0] channel;
  logic [6:0] data_one;
  logic [6:0] data_two;
  logic [7:0] sysex_length;
  logic       last_of_run;

  ble_midi_packet_parser_unit uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .packet_byte(packet_byte),
    .first_in_packet(first_in_packet),
    .last_in_packet(last_in_packet),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .event_kind(event_kind),
    .channel(channel),
    .data_one(data_one),
    .data_two(data_two),
    .sysex_length(sysex_length),
    .last_of_run(last_of_run)
  );

  always #2 clk = ~clk;

  // Parser state mirrored for prediction.
  logic [7:0]   limit_shadow = SYSEX_LIMIT_RESET;
  parse_state_t parse_state = PARSE_GROUP;
  logic         sysex_open = 1'b0;
  logic [7:0]   sysex_seen = 8'd0;
  logic [7:0]   status_held = 8'd0;
  logic [6:0]   first_data = 7'd0;
  logic [1:0]   bytes_to_skip = 2'd0;

  event_word_t step_buf[2];
  int          step_n;
  event_word_t awaited_events[$];

  logic [7:0] pkt_q[$];
  logic       gen_in_sysex = 1'b0;
  bit         sender_eager = 1'b0;
  int         burst_left = 0;
  int         words_sent = 0;
  int         events_checked = 0;
  int         mismatches = 0;
  int         kind_seen[8];
  int         hold_request = 0;

  rx_style_t stall_style = RX_OPEN;
  int        style_left = 0;
  int        hold_left = 0;
  int        hold_seen = 0;
  int        tick = 0;
  int        quiet_cycles = 0;

  function automatic void post_event(event_kind_t k, logic [3:0] ch, logic [6:0] d1,
                                     logic [6:0] d2, logic [7:0] len);
    event_word_t w;
    w.ev.kind = k;
    w.ev.channel = ch;
    w.ev.data_one = d1;
    w.ev.data_two = d2;
    w.ev.sysex_length = len;
    w.last = 1'b0;
    if (step_n < 2) begin
      step_buf[step_n] = w;
      step_n++;
    end
  endfunction

  function automatic void close_sysex(event_kind_t k);
    post_event(k, 4'd0, 7'd0, 7'd0, sysex_seen);
    sysex_open = 1'b0;
    sysex_seen = 8'd0;
  endfunction

  function automatic void channel_event(logic [7:0] st, logic [6:0] d1, logic [6:0] d2);
    case (st[7:4])
      HI_NOTE_OFF: post_event(EV_NOTE_OFF, st[3:0], d1, d2, 8'd0);
      HI_NOTE_ON:  post_event(EV_NOTE_ON, st[3:0], d1, d2, 8'd0);
      HI_CTRL:     post_event(EV_CTRL_CHANGE, st[3:0], d1, d2, 8'd0);
      HI_PROGRAM:  post_event(EV_PROG_CHANGE, st[3:0], d1, 7'd0, 8'd0);
      default: begin
      end
    endcase
  endfunction

  function automatic void take_first_data(logic [7:0] b);
    if (status_held[7:4] == HI_PROGRAM || status_held[7:4] == HI_PRESSURE) begin
      channel_event(status_held, b[6:0], 7'd0);
      parse_state = PARSE_GROUP;
    end else begin
      first_data = b[6:0];
      parse_state = PARSE_SECOND_DATA;
    end
  endfunction

  function automatic void group_byte(logic [7:0] b, logic is_last);
    if (sysex_open) begin
      if (b[7]) begin
        if (is_last) close_sysex(EV_SYSEX_ABORT);
        else parse_state = PARSE_SYSEX_STAMP;
      end else if (sysex_seen < limit_shadow) begin
        post_event(EV_SYSEX_BYTE, 4'd0, b[6:0], 7'd0, 8'd0);
        sysex_seen++;
      end else begin
        close_sysex(EV_SYSEX_ABORT);
      end
    end else if (b[7]) begin
      parse_state = PARSE_AFTER_STAMP;
    end else if (status_held != 8'd0) begin
      take_first_data(b);
    end
  endfunction

  function automatic void status_byte(logic [7:0] b);
    parse_state = PARSE_GROUP;
    if (!b[7]) begin
      if (status_held != 8'd0) take_first_data(b);
    end else if (b == ST_SYSEX_START) begin
      sysex_open = 1'b1;
      sysex_seen = 8'd0;
      status_held = 8'd0;
    end else if (b >= ST_REALTIME || b == ST_SYSEX_END) begin
    end else if (b >= ST_MTC_QUARTER) begin
      status_held = 8'd0;
      if (b == ST_SONG_POS) bytes_to_skip = 2'd2;
      else if (b == ST_MTC_QUARTER || b == ST_SONG_SEL) bytes_to_skip = 2'd1;
      else bytes_to_skip = 2'd0;
      if (bytes_to_skip != 2'd0) parse_state = PARSE_SKIP;
    end else begin
      status_held = b;
      parse_state = PARSE_FIRST_DATA;
    end
  endfunction

  function automatic void predict_word(logic [7:0] b, logic is_first, logic is_last);
    int i;
    step_n = 0;
    if (is_first) begin
      if (parse_state == PARSE_SYSEX_STAMP && sysex_open) close_sysex(EV_SYSEX_ABORT);
      parse_state = PARSE_GROUP;
      bytes_to_skip = 2'd0;
    end else begin
      case (parse_state)
        PARSE_AFTER_STAMP: status_byte(b);
        PARSE_FIRST_DATA:  take_first_data(b);
        PARSE_SECOND_DATA: begin
          channel_event(status_held, first_data, b[6:0]);
          parse_state = PARSE_GROUP;
        end
        PARSE_SKIP: begin
          if (bytes_to_skip > 2'd0) bytes_to_skip--;
          if (bytes_to_skip == 2'd0) parse_state = PARSE_GROUP;
        end
        PARSE_SYSEX_STAMP: begin
          parse_state = PARSE_GROUP;
          if (sysex_open && b == ST_SYSEX_END) begin
            close_sysex(EV_SYSEX_OK);
          end else begin
            if (sysex_open) close_sysex(EV_SYSEX_ABORT);
            group_byte(b, is_last);
          end
        end
        default: begin
          parse_state = PARSE_GROUP;
          group_byte(b, is_last);
        end
      endcase
    end
    if (is_last) begin
      parse_state = PARSE_GROUP;
      bytes_to_skip = 2'd0;
    end
    if (step_n > 0) step_buf[step_n - 1].last = 1'b1;
    for (i = 0; i < step_n; i++) awaited_events.push_back(step_buf[i]);
  endfunction

  function automatic logic [7:0] random_stamp();
    return {1'b1, 7'($urandom)};
  endfunction

  function automatic logic [7:0] random_data();
    if ($urandom_range(0, 19) == 0) return 8'($urandom);
    return {1'b0, 7'($urandom)};
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 40)
      $display("mismatch at event %0d: %s got %0h, expected %0h",
               events_checked, what, got, want);
    mismatches++;
  endtask

  task automatic send_word(input logic [7:0] b, input logic is_first, input logic is_last);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (!sender_eager && $urandom_range(0, 2) != 0) gap = $urandom_range(1, 7);
    end
    burst_left--;
    if (sender_eager) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    packet_byte <= b;
    first_in_packet <= is_first;
    last_in_packet <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(b, is_first, is_last);
    words_sent++;
  endtask

  task automatic send_packet(input bit with_header);
    int i;
    if (with_header) send_word(8'($urandom), 1'b1, pkt_q.size() == 0);
    for (i = 0; i < pkt_q.size(); i++) send_word(pkt_q[i], 1'b0, i == pkt_q.size() - 1);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_events.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_sysex_limit(input logic [7:0] value);
    settle();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    limit_shadow = value;
    cfg_we <= 1'b0;
  endtask

  task automatic build_random_packet();
    int roll;
    int n;
    int reps;
    logic [7:0] st;
    pkt_q.delete();
    repeat ($urandom_range(1, 4)) begin
      roll = $urandom_range(0, 99);
      if (gen_in_sysex) begin
        repeat ($urandom_range(0, 8)) pkt_q.push_back({1'b0, 7'($urandom)});
        if (roll < 40) begin
          pkt_q.push_back(random_stamp());
          pkt_q.push_back(ST_SYSEX_END);
          gen_in_sysex = 1'b0;
        end else if (roll < 50) begin
          pkt_q.push_back(random_stamp());
          pkt_q.push_back(8'($urandom));
          gen_in_sysex = 1'b0;
        end
      end else if (roll < 45) begin
        st = {4'($urandom_range(8, 14)), 4'($urandom)};
        n = (st[7:4] == HI_PROGRAM || st[7:4] == HI_PRESSURE) ? 1 : 2;
        reps = $urandom_range(1, 3);
        pkt_q.push_back(random_stamp());
        pkt_q.push_back(st);
        repeat (reps * n) pkt_q.push_back(random_data());
      end else if (roll < 55) begin
        repeat ($urandom_range(1, 2)) pkt_q.push_back({1'b0, 7'($urandom)});
      end else if (roll < 68) begin
        pkt_q.push_back(random_stamp());
        pkt_q.push_back(ST_SYSEX_START);
        gen_in_sysex = 1'b1;
      end else if (roll < 76) begin
        pkt_q.push_back(random_stamp());
        if (roll < 72) pkt_q.push_back(8'($urandom_range(ST_REALTIME, 8'hFF)));
        else pkt_q.push_back(ST_SYSEX_END);
      end else if (roll < 84) begin
        pkt_q.push_back(random_stamp());
        pkt_q.push_back(8'($urandom_range(ST_MTC_QUARTER, ST_SYSEX_END - 1)));
        repeat ($urandom_range(0, 2)) pkt_q.push_back(random_data());
      end else begin
        repeat ($urandom_range(1, 3)) pkt_q.push_back(8'($urandom));
      end
    end
    if ($urandom_range(0, 9) == 0 && pkt_q.size() > 0) pkt_q.delete(pkt_q.size() - 1);
  endtask

  task automatic test_channel_messages();
    pkt_q = '{8'h12, 8'h80, {HI_NOTE_ON, 4'hF}, 8'h00, 8'h7F, 8'h3C, 8'h40, 8'hFF,
              {HI_CTRL, 4'h0}, 8'hFF, 8'h80, 8'hC1, {HI_PROGRAM, 4'h5}, 8'h7F, 8'h87,
              {HI_NOTE_OFF, 4'h9}, 8'h3C};
    send_packet(1'b1);
    pkt_q = '{8'h3C, 8'h00};
    send_packet(1'b1);
  endtask

  task automatic test_sysex_framing();
    pkt_q = '{8'h80, ST_SYSEX_START, 8'h00, 8'h7F, 8'h81, ST_SYSEX_END};
    send_packet(1'b1);
    pkt_q = '{8'h80, ST_SYSEX_START, 8'h01};
    send_packet(1'b1);
    pkt_q = '{8'h02, 8'h81, 8'h20, 8'h83};
    send_packet(1'b1);
    pkt_q = '{8'h80, ST_SYSEX_START, 8'h05, 8'h81};
    send_packet(1'b1);
    pkt_q = '{8'h82};
    send_packet(1'b1);
  endtask

  task automatic test_system_bytes();
    pkt_q = '{8'h80, {HI_NOTE_ON, 4'h2}, 8'h10, 8'h20, 8'h81, ST_REALTIME, 8'h30, 8'h40,
              8'h84, ST_SYSEX_END, 8'h50, 8'h60, 8'h82, ST_SONG_POS, 8'h7F, 8'h7F,
              8'h33, 8'h83, ST_SONG_SEL};
    send_packet(1'b1);
  endtask

  task automatic test_sysex_limits();
    int i;
    set_sysex_limit(8'd1);
    pkt_q = '{8'h80, ST_SYSEX_START, 8'h01, 8'h02, 8'h03, 8'h81, ST_SYSEX_END};
    send_packet(1'b1);
    set_sysex_limit(8'd255);
    pkt_q = '{8'h80, ST_SYSEX_START};
    for (i = 0; i < 120; i++) pkt_q.push_back({1'b0, 7'(i)});
    send_packet(1'b1);
    pkt_q.delete();
    for (i = 0; i < 136; i++) pkt_q.push_back({1'b0, 7'(i + 5)});
    pkt_q.push_back(8'h81);
    pkt_q.push_back(ST_SYSEX_END);
    send_packet(1'b1);
  endtask

  task automatic test_random_traffic(input logic [7:0] limit, input int n_words);
    int stop_at;
    set_sysex_limit(limit);
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      build_random_packet();
      send_packet($urandom_range(0, 29) != 0);
    end
  endtask

  task automatic test_back_pressure();
    int stop_at;
    settle();
    sender_eager = 1'b1;
    hold_request++;
    stop_at = words_sent + 60;
    while (words_sent < stop_at) begin
      build_random_packet();
      send_packet(1'b1);
    end
    sender_eager = 1'b0;
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_seen != hold_request) begin
      hold_seen = hold_request;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (style_left == 0) begin
        stall_style = rx_style_t'($urandom_range(0, 3));
        style_left = $urandom_range(40, 300);
      end
      style_left--;
      tick++;
      case (stall_style)
        RX_OPEN:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 4) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
        default:  out_stall <= ((tick % 7) < 3);
      endcase
    end
  end

  always @(posedge clk) begin : check_events
    event_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_events.size() == 0) begin
        report_mismatch("event with none expected, kind", event_kind, 0);
      end else begin
        want = awaited_events.pop_front();
        if (event_kind !== want.ev.kind) report_mismatch("event_kind", event_kind, want.ev.kind);
        if (channel !== want.ev.channel) report_mismatch("channel", channel, want.ev.channel);
        if (data_one !== want.ev.data_one)
          report_mismatch("data_one", data_one, want.ev.data_one);
        if (data_two !== want.ev.data_two)
          report_mismatch("data_two", data_two, want.ev.data_two);
        if (sysex_length !== want.ev.sysex_length)
          report_mismatch("sysex_length", sysex_length, want.ev.sysex_length);
        if (last_of_run !== want.last) report_mismatch("last_of_run", last_of_run, want.last);
        kind_seen[want.ev.kind]++;
      end
      events_checked++;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles, %0d events still awaited.",
               QUIET_LIMIT, awaited_events.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_channel_messages();
    test_sysex_framing();
    test_system_bytes();
    test_sysex_limits();
    test_random_traffic(8'd192, 200);
    test_random_traffic(8'd1, 150);
    test_random_traffic(8'd255, 150);
    test_random_traffic(8'($urandom_range(2, 12)), 150);
    test_back_pressure();
    test_random_traffic(8'($urandom_range(13, 254)), 120);
    settle();
    $display("Sent %0d packet bytes and checked %0d events with %0d mismatches.",
             words_sent, events_checked, mismatches);
    $display("Channel events %0d, sysex bytes %0d, sysex closed ok %0d, aborted %0d.",
             kind_seen[EV_NOTE_OFF] + kind_seen[EV_NOTE_ON] + kind_seen[EV_CTRL_CHANGE] +
             kind_seen[EV_PROG_CHANGE], kind_seen[EV_SYSEX_BYTE], kind_seen[EV_SYSEX_OK],
             kind_seen[EV_SYSEX_ABORT]);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
